/* rtl/core/lruc_pkg.sv */
`timescale 1ns / 1ps

package lruc_pkg;

  // Fixed field widths of the request and response items.
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 3;
  localparam int STAMP_W = 32;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  // Operation codes carried in the mode field.
  localparam mode_t MODE_LOOKUP = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the accepted request item
    logic scan;    // scan phase is active
    logic issue;   // read the entry at the issue index
    logic commit;  // update the cache and load the response register
  } lruc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // the latched request is a lookup or an insert
    logic scan_done;  // the compare stage found its entry or saw the last one
    logic rsp_free;   // the response register can take a new item
  } lruc_stat_t;

endpackage

/* rtl/core/lruc_req_if.sv */
`timescale 1ns / 1ps

interface lruc_req_if import lruc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key_hash;
  logic [KEY_W-1:0]   key_size;
  logic [KEY_W-1:0]   key_offset;
  logic [KEY_W-1:0]   key_path_id;
  logic [VALUE_W-1:0] write_value;

  modport source (
    output valid, mode, key_hash, key_size, key_offset, key_path_id, write_value,
    input  ready
  );
  modport sink (
    input  valid, mode, key_hash, key_size, key_offset, key_path_id, write_value,
    output ready
  );
endinterface

/* rtl/core/lruc_rsp_if.sv */
`timescale 1ns / 1ps

interface lruc_rsp_if import lruc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] read_value;
  logic [SLOT_W-1:0]  slot;

  modport source (
    output valid, hit, read_value, slot,
    input  ready
  );
  modport sink (
    input  valid, hit, read_value, slot,
    output ready
  );
endinterface

/* rtl/core/lru_tagged_entry_cache.sv */
`timescale 1ns / 1ps

// Small fully associative cache with least-recently-used replacement by use
// stamps. Each request item is a lookup, an insert or a clear; each gives one
// response item. The tags and stamps sit in memories with a single read port,
// so the controller scans one entry per cycle: a lookup or an insert reads the
// entries in index order and stops at the entry that decides it or at the last
// one, and a clear or an unused mode does not scan. The response appears the
// cycle after the commit step and is held in a register, so the next request
// is taken while it waits.
module lru_tagged_entry_cache import lruc_pkg::*; #(
  parameter int ENTRIES    = 8,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  lruc_req_if.sink   req,
  lruc_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  lruc_cmd_t        cmd;
  lruc_stat_t       stat;
  logic [IDX_W-1:0] issue_idx;

  // Sequencer for accept, scan and commit.
  lruc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .issue_idx (issue_idx),
    .stat      (stat)
  );

  // Storage, compare, replacement choice and response register.
  lruc_dpath #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .issue_idx   (issue_idx),
    .stat        (stat),
    .mode        (req.mode),
    .key_hash    (req.key_hash),
    .key_size    (req.key_size),
    .key_offset  (req.key_offset),
    .key_path_id (req.key_path_id),
    .write_value (req.write_value),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .hit         (rsp.hit),
    .read_value  (rsp.read_value),
    .slot        (rsp.slot)
  );

endmodule

/* rtl/core/lruc_ctrl.sv */
`timescale 1ns / 1ps

module lruc_ctrl import lruc_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  output lruc_cmd_t                  cmd,
  output logic [$clog2(ENTRIES)-1:0] issue_idx,
  input  lruc_stat_t                 stat
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   issue_more;
  logic   fire;

  assign fire = req_valid && req_ready;

  // Commands follow the state directly.
  always_comb begin
    cmd.load   = fire;
    cmd.scan   = (state == ST_SCAN);
    cmd.issue  = (state == ST_SCAN) && issue_more;
    cmd.commit = (state == ST_COMMIT) && stat.rsp_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fire) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stat.need_scan || stat.scan_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, ready and the scan issue counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      req_ready  <= 1'b0;
      issue_idx  <= '0;
      issue_more <= 1'b0;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == ST_IDLE);
      if (fire) begin
        issue_idx  <= '0;
        issue_more <= 1'b1;
      end else if (cmd.issue) begin
        if (issue_idx == LAST_IDX) begin
          issue_more <= 1'b0;
        end else begin
          issue_idx <= issue_idx + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/lruc_dpath.sv */
`timescale 1ns / 1ps

module lruc_dpath import lruc_pkg::*; #(
  parameter int ENTRIES    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lruc_cmd_t                  cmd,
  input  logic [$clog2(ENTRIES)-1:0] issue_idx,
  output lruc_stat_t                 stat,
  input  logic [MODE_W-1:0]          mode,
  input  logic [KEY_W-1:0]           key_hash,
  input  logic [KEY_W-1:0]           key_size,
  input  logic [KEY_W-1:0]           key_offset,
  input  logic [KEY_W-1:0]           key_path_id,
  input  logic [VALUE_W-1:0]         write_value,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic                       hit,
  output logic [VALUE_W-1:0]         read_value,
  output logic [SLOT_W-1:0]          slot
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [KEY_W-1:0]      hash;
    logic [KEY_W-1:0]      size;
    logic [KEY_W-1:0]      offset;
    logic [KEY_W-1:0]      path;
    logic [DATA_WIDTH-1:0] data;
  } entry_t;

  // Latched request item.
  mode_t                 r_mode;
  logic [KEY_W-1:0]      r_hash;
  logic [KEY_W-1:0]      r_size;
  logic [KEY_W-1:0]      r_offset;
  logic [KEY_W-1:0]      r_path;
  logic [DATA_WIDTH-1:0] r_wdata;

  // Entry storage: tags and data, and use stamps, each one read port.
  entry_t tag_mem   [ENTRIES];
  stamp_t stamp_mem [ENTRIES];
  entry_t rd_entry;
  stamp_t rd_stamp;

  // Per-entry flags; a stamp whose live bit is clear reads as zero.
  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] stamp_live;
  stamp_t             stamp_counter;

  // Compare stage.
  logic                  cmp_vld;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  found;
  logic [IDX_W-1:0]      pick;
  stamp_t                min_stamp;
  logic [DATA_WIDTH-1:0] found_data;

  logic                  is_lookup;
  logic                  is_insert;
  logic                  key_eq;
  logic                  cur_valid;
  stamp_t                cur_stamp;
  logic                  brk;
  logic                  step;
  logic                  hit_c;
  logic                  touch;
  stamp_t                cnt_inc;
  logic                  wrap;
  stamp_t                stamp_new;
  logic [ENTRIES-1:0]    pick_onehot;
  logic [DATA_WIDTH-1:0] data_sel;
  logic [DATA_WIDTH+VALUE_W-1:0] wv_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] rv_ext;
  logic [IDX_W+SLOT_W-1:0]       slot_ext;

  assign is_lookup = (r_mode == MODE_LOOKUP);
  assign is_insert = (r_mode == MODE_INSERT);

  // Widen or cut the data word between the port and storage widths.
  assign wv_ext   = {{DATA_WIDTH{1'b0}}, write_value};
  assign data_sel = is_insert ? r_wdata : found_data;
  assign rv_ext   = {{VALUE_W{1'b0}}, data_sel};
  assign slot_ext = {{SLOT_W{1'b0}}, pick};

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode   <= mode;
      r_hash   <= key_hash;
      r_size   <= key_size;
      r_offset <= key_offset;
      r_path   <= key_path_id;
      r_wdata  <= wv_ext[DATA_WIDTH-1:0];
    end
  end

  // Compare logic for the entry read in the previous cycle.
  always_comb begin
    key_eq    = (rd_entry.hash == r_hash) && (rd_entry.size == r_size) &&
                (rd_entry.offset == r_offset) && (rd_entry.path == r_path);
    cur_valid = entry_valid[cmp_idx];
    cur_stamp = stamp_live[cmp_idx] ? rd_stamp : '0;
    brk       = is_lookup ? (cur_valid && key_eq) : (!cur_valid || key_eq);
    step      = cmd.scan && cmp_vld;
    stat.need_scan = is_lookup || is_insert;
    stat.scan_done = step && (brk || (cmp_idx == LAST_IDX));
    stat.rsp_free  = !rsp_valid || rsp_ready;
  end

  // Restamp arithmetic: a wrap clears every stamp before stamp 1 is given.
  always_comb begin
    hit_c       = (is_lookup && found) || is_insert;
    touch       = cmd.commit && hit_c;
    cnt_inc     = stamp_counter + 1'b1;
    wrap        = (cnt_inc == '0);
    stamp_new   = wrap ? stamp_t'(1) : cnt_inc;
    pick_onehot = {{(ENTRIES-1){1'b0}}, 1'b1} << pick;
  end

  // Memory read and write ports.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_entry <= tag_mem[issue_idx];
      rd_stamp <= stamp_mem[issue_idx];
    end
    if (cmd.commit && is_insert) begin
      tag_mem[pick] <= '{hash: r_hash, size: r_size, offset: r_offset,
                         path: r_path, data: r_wdata};
    end
    if (touch) begin
      stamp_mem[pick] <= stamp_new;
    end
  end

  // Scan pipeline flag and search result.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      cmp_vld <= cmd.issue;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (step && brk) begin
        found <= 1'b1;
      end
    end
  end

  // Pick tracking: the first breaking entry, else the lowest-index oldest stamp.
  always_ff @(posedge clk) begin
    cmp_idx <= issue_idx;
    if (step) begin
      if (brk) begin
        pick       <= cmp_idx;
        found_data <= rd_entry.data;
      end else if ((cmp_idx == '0) || (cur_stamp < min_stamp)) begin
        pick      <= cmp_idx;
        min_stamp <= cur_stamp;
      end
    end
  end

  // Cache state update at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= '0;
      stamp_live    <= '0;
      stamp_counter <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.commit && (r_mode == MODE_CLEAR)) begin
        entry_valid   <= '0;
        stamp_live    <= '0;
        stamp_counter <= '0;
      end else if (touch) begin
        stamp_counter <= stamp_new;
        stamp_live    <= (wrap ? '0 : stamp_live) | pick_onehot;
        if (is_insert) entry_valid <= entry_valid | pick_onehot;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit        <= hit_c;
      read_value <= hit_c ? rv_ext[VALUE_W-1:0] : '0;
      slot       <= hit_c ? slot_ext[SLOT_W-1:0] : '0;
    end
  end

endmodule

/* rtl/core/lruc_checker.sv */
`timescale 1ns / 1ps

module lruc_checker import lruc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               hit,
  input logic [VALUE_W-1:0] read_value,
  input logic [SLOT_W-1:0]  slot
);

  // A stalled response item keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) &&
      $stable(read_value) && $stable(slot))
    else $error("response item changed while stalled");

  // One request at a time: acceptance closes the request side.
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // A new response only comes out of a busy period.
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response appeared without a request in work");

  // A miss or a clear reports zero data and slot.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> (read_value == '0) && (slot == '0))
    else $error("miss response carries data");

endmodule

bind lru_tagged_entry_cache lruc_checker u_lruc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .hit        (rsp.hit),
  .read_value (rsp.read_value),
  .slot       (rsp.slot)
);

/* tb/sv/tb_lru_tagged_entry_cache.sv */
`timescale 1ns / 1ps

module tb_lru_tagged_entry_cache;
  import lruc_pkg::*;

  localparam int CACHE_ENTRIES = 8;
  localparam int RANDOM_ITEMS  = 850;
  localparam int POOL_KEYS     = 12;
  localparam int DRAIN_CYCLES  = 30;

  // The one mode code that the package leaves without a name.
  localparam mode_t MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] hash;
    logic [KEY_W-1:0] size;
    logic [KEY_W-1:0] offset;
    logic [KEY_W-1:0] path;
  } cache_key_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic [SLOT_W-1:0]  slot;
  } cache_reply_t;

  // One request item, with an optional hand-written reply.
  typedef struct packed {
    mode_t              mode;
    cache_key_t         key;
    logic [VALUE_W-1:0] wdata;
    bit                 fixed;
    cache_reply_t       reply;
  } op_row_t;

  logic clk;
  logic rst;
  logic quiet;

  lruc_req_if req_if ();
  lruc_rsp_if rsp_if ();

  lru_tagged_entry_cache #(
    .ENTRIES    (CACHE_ENTRIES),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Shadow copy of the cache contents.
  logic               held     [CACHE_ENTRIES];
  cache_key_t         tag_key  [CACHE_ENTRIES];
  logic [VALUE_W-1:0] tag_data [CACHE_ENTRIES];
  stamp_t             stamp    [CACHE_ENTRIES];
  stamp_t             stamp_ctr;

  cache_reply_t rsp_owed[$];
  op_row_t      dir_rows[$];
  op_row_t      cur_row;
  cache_key_t   key_pool[POOL_KEYS];

  int errors;
  int replies_checked;
  int n_hits, n_misses, n_inserts, n_evicts, n_clears, n_unused;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void wipe_cache_model();
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      held[i]  = 1'b0;
      stamp[i] = '0;
    end
    stamp_ctr = '0;
  endfunction

  // Advance the use counter; on wrap every stamp is cleared and the count restarts at 1.
  function automatic stamp_t bump_stamp();
    stamp_ctr = stamp_ctr + 1'b1;
    if (stamp_ctr == '0) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) stamp[i] = '0;
      stamp_ctr = stamp_t'(1);
    end
    return stamp_ctr;
  endfunction

  // Apply one request to the shadow cache and return the reply it must produce.
  function automatic cache_reply_t apply_cache_op(input mode_t m, input cache_key_t k,
                                                  input logic [VALUE_W-1:0] wd);
    cache_reply_t r;
    int pick;
    bit found;
    r = '0;
    pick = 0;
    found = 1'b0;
    case (m)
      MODE_LOOKUP: begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (!found && held[i] && tag_key[i] == k) begin
            pick = i;
            found = 1'b1;
          end
        end
        if (found) begin
          stamp[pick] = bump_stamp();
          r.hit = 1'b1;
          r.read_value = tag_data[pick];
          r.slot = pick[SLOT_W-1:0];
          n_hits++;
        end else begin
          n_misses++;
        end
      end
      MODE_INSERT: begin
        // First empty or matching entry wins; otherwise the oldest stamp, lowest index on ties.
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (!found) begin
            if (!held[i] || tag_key[i] == k) begin
              pick = i;
              found = 1'b1;
            end else if (stamp[i] < stamp[pick]) begin
              pick = i;
            end
          end
        end
        if (!found) n_evicts++;
        held[pick] = 1'b1;
        tag_key[pick] = k;
        tag_data[pick] = wd;
        stamp[pick] = bump_stamp();
        r.hit = 1'b1;
        r.read_value = wd;
        r.slot = pick[SLOT_W-1:0];
        n_inserts++;
      end
      MODE_CLEAR: begin
        wipe_cache_model();
        n_clears++;
      end
      default: begin
        n_unused++;
      end
    endcase
    return r;
  endfunction

  function automatic op_row_t mk_row(input mode_t m, input cache_key_t k,
                                     input logic [VALUE_W-1:0] wd, input bit fx,
                                     input logic h, input logic [VALUE_W-1:0] rv,
                                     input logic [SLOT_W-1:0] sl);
    op_row_t r;
    r.mode = m;
    r.key = k;
    r.wdata = wd;
    r.fixed = fx;
    r.reply.hit = h;
    r.reply.read_value = rv;
    r.reply.slot = sl;
    return r;
  endfunction

  // Mostly keys from a small pool so that lookups hit and inserts evict; some near misses.
  function automatic op_row_t random_row();
    op_row_t r;
    int roll;
    int bit_idx;
    cache_key_t k;
    roll = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, POOL_KEYS-1)];
    if ($urandom_range(0, 99) < 10) begin
      k = {$urandom, $urandom, $urandom, $urandom};
    end else if ($urandom_range(0, 99) < 12) begin
      bit_idx = $urandom_range(0, 4*KEY_W-1);
      k[bit_idx] = ~k[bit_idx];
    end
    if (roll < 46) r.mode = MODE_LOOKUP;
    else if (roll < 96) r.mode = MODE_INSERT;
    else if (roll < 98) r.mode = MODE_CLEAR;
    else r.mode = MODE_UNUSED;
    r.key = k;
    r.wdata = $urandom;
    r.fixed = 1'b0;
    r.reply = '0;
    return r;
  endfunction

  // Present one item and hold it until the cache takes it; sometimes idle first.
  task automatic send_item(input op_row_t r);
    if (!quiet && $urandom_range(0, 99) < 33) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.key_hash    <= r.key.hash;
    req_if.key_size    <= r.key.size;
    req_if.key_offset  <= r.key.offset;
    req_if.key_path_id <= r.key.path;
    req_if.write_value <= r.wdata;
    cur_row            <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Response side stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 33);
  end

  // Queue the expected reply for each accepted request and check each delivered reply.
  always @(posedge clk) begin
    cache_reply_t want;
    cache_key_t k;
    if (!rst && req_if.valid && req_if.ready) begin
      k = {req_if.key_hash, req_if.key_size, req_if.key_offset, req_if.key_path_id};
      want = apply_cache_op(req_if.mode, k, req_if.write_value);
      rsp_owed.push_back(cur_row.fixed ? cur_row.reply : want);
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (rsp_owed.size() == 0) begin
        log_mismatch($sformatf("reply with nothing outstanding: hit %b value %h slot %0d",
                               rsp_if.hit, rsp_if.read_value, rsp_if.slot));
      end else begin
        want = rsp_owed.pop_front();
        replies_checked++;
        if (rsp_if.hit !== want.hit)
          log_mismatch($sformatf("reply %0d hit %b, expected %b",
                                 replies_checked, rsp_if.hit, want.hit));
        if (rsp_if.read_value !== want.read_value)
          log_mismatch($sformatf("reply %0d read_value %h, expected %h",
                                 replies_checked, rsp_if.read_value, want.read_value));
        if (rsp_if.slot !== want.slot)
          log_mismatch($sformatf("reply %0d slot %0d, expected %0d",
                                 replies_checked, rsp_if.slot, want.slot));
      end
    end
  end

  initial begin
    op_row_t r;
    int done_items;
    cache_key_t kz;
    cache_key_t ko;
    cache_key_t kf;

    rst = 1'b1;
    quiet = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_LOOKUP;
    req_if.key_hash = '0;
    req_if.key_size = '0;
    req_if.key_offset = '0;
    req_if.key_path_id = '0;
    req_if.write_value = '0;
    cur_row = '0;
    errors = 0;
    replies_checked = 0;
    n_hits = 0;
    n_misses = 0;
    n_inserts = 0;
    n_evicts = 0;
    n_clears = 0;
    n_unused = 0;
    wipe_cache_model();

    // Directed rows: empty misses, extremes, one-part near misses, update, fill, evict, clear.
    kz = '0;
    ko = '1;
    dir_rows.push_back(mk_row(MODE_LOOKUP, kz, '0, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, ko, '1, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_INSERT, kz, '1, 1, 1'b1, '1, 3'd0));
    dir_rows.push_back(mk_row(MODE_INSERT, ko, '0, 1, 1'b1, '0, 3'd1));
    dir_rows.push_back(mk_row(MODE_LOOKUP, kz, '0, 1, 1'b1, '1, 3'd0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, ko, '1, 1, 1'b1, '0, 3'd1));
    dir_rows.push_back(mk_row(MODE_LOOKUP, {32'd1, 32'd0, 32'd0, 32'd0}, '0, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, {32'd0, 32'd1, 32'd0, 32'd0}, '0, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, {32'd0, 32'd0, 32'd1, 32'd0}, '0, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, {32'd0, 32'd0, 32'd0, 32'd1}, '0, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP,
                              {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
                              '0, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_INSERT, kz, 32'h1234_5678, 1, 1'b1, 32'h1234_5678, 3'd0));
    for (int i = 2; i < CACHE_ENTRIES; i++) begin
      kf = {32'h8000_0000 | i, i << 8, ~i, 32'hA5A5_0000 | i};
      dir_rows.push_back(mk_row(MODE_INSERT, kf, 32'hC0DE_0000 | i, 1, 1'b1,
                                32'hC0DE_0000 | i, i[SLOT_W-1:0]));
    end
    // Full cache: the new key replaces the entry used longest ago.
    dir_rows.push_back(mk_row(MODE_INSERT, {32'hDEAD_BEEF, 32'd1, 32'd2, 32'd3},
                              32'h5555_AAAA, 0, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, ko, '0, 0, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, kz, '0, 0, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_UNUSED, ko, '1, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_CLEAR, ko, '1, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_LOOKUP, kz, '0, 1, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(MODE_INSERT, ko, 32'hAAAA_5555, 1, 1'b1, 32'hAAAA_5555, 3'd0));
    dir_rows.push_back(mk_row(MODE_CLEAR, kz, '0, 1, 1'b0, '0, '0));

    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom, $urandom, $urandom};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random traffic, with a stretch in the middle where neither side idles.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      quiet <= (done_items >= 300 && done_items < 450);
      if ($urandom_range(0, 99) < 3)
        key_pool[$urandom_range(0, POOL_KEYS-1)] = {$urandom, $urandom, $urandom, $urandom};
      r = random_row();
      send_item(r);
      if (r.mode != MODE_UNUSED) done_items++;
    end
    req_if.valid <= 1'b0;

    while (rsp_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d replies checked; lookups %0d hit / %0d missed, %0d inserts",
             replies_checked, n_hits, n_misses, n_inserts);
    $display("summary: %0d evictions, %0d clears, %0d unused-mode items, %0d mismatches",
             n_evicts, n_clears, n_unused, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
